// ----- sv/mep_pkg.sv -----
package mep_pkg;

    // Sizes of the block
    localparam int PALETTE_SIZE  = 255;
    localparam int FRACTION_BITS = 59;
    localparam int MAX_DIMENSION = 4096;

    localparam int PAL_AW     = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int VAL_W      = 64;
    localparam int WIDE_W     = 2 * VAL_W;
    localparam int STEP_W     = 63;
    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int COUNT_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int RGB_W      = 3 * COLOR_W;
    localparam int INDEX_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // |z|^2 >= 4 in the product scale
    localparam int FOUR_BIT = 2 * FRACTION_BITS + 2;

    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [WIDE_W-1:0] t_wide;

    localparam t_val  SIGN_MASK = {1'b1, {(VAL_W-1){1'b0}}};
    localparam t_wide FRAC_MASK = (t_wide'(1) << FRACTION_BITS) - t_wide'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_RE   = 3'd0,
        CFG_CENTER_IM   = 3'd1,
        CFG_PIXEL_STEP  = 3'd2,
        CFG_MAX_ITER    = 3'd3,
        CFG_IMAGE_WIDTH = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_reg;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_PIXEL = 1'b1
    } t_cmd;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [INDEX_W-1:0] palette_index;
        logic [COLOR_W-1:0] load_red;
        logic [COLOR_W-1:0] load_green;
        logic [COLOR_W-1:0] load_blue;
    } t_in_word;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic               escaped;
        logic [COUNT_W-1:0] iteration_count;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_out_word;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [RGB_W-1:0]  rgb;
    } t_pal_wr;

    // Clamp the image size to 1..MAX_DIMENSION and return size - 1
    function automatic logic [DIM_W-1:0] span_of(input logic [DIM_W-1:0] dim);
        logic [DIM_W-1:0] r;
        if (dim == '0) begin
            r = '0;
        end else if (32'(dim) > MAX_DIMENSION) begin
            r = DIM_W'(MAX_DIMENSION - 1);
        end else begin
            r = dim - DIM_W'(1);
        end
        return r;
    endfunction

    function automatic t_val magnitude(input t_val v);
        return v[VAL_W-1] ? (t_val'(0) - v) : v;
    endfunction

    // Drop the fraction bits of a magnitude; round toward minus infinity
    // for the signed value, so a negative magnitude rounds up.
    function automatic t_wide wscale(input t_wide a, input logic neg);
        t_wide r;
        r = a >> FRACTION_BITS;
        if (neg && ((a & FRAC_MASK) != '0)) begin
            r = r + t_wide'(1);
        end
        return r;
    endfunction

    // base plus or minus a magnitude, saturated to the signed 64-bit range
    function automatic t_val sat_add(input t_val base, input t_wide mag, input logic neg);
        t_val         b;
        t_val         r;
        logic [VAL_W:0] s;
        logic         hi_nz;
        b     = base ^ SIGN_MASK;
        hi_nz = |mag[WIDE_W-1:VAL_W];
        if (!neg) begin
            s = {1'b0, b} + {1'b0, mag[VAL_W-1:0]};
            r = (hi_nz || s[VAL_W]) ? '1 : s[VAL_W-1:0];
        end else begin
            s = {1'b0, b} - {1'b0, mag[VAL_W-1:0]};
            r = (hi_nz || s[VAL_W]) ? '0 : s[VAL_W-1:0];
        end
        return r ^ SIGN_MASK;
    endfunction

endpackage

// ----- sv/mep_in_if.sv -----
interface mep_in_if import mep_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/mep_out_if.sv -----
interface mep_out_if import mep_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/mandelbrot_escape_pixel.sv -----
// Escape-time Mandelbrot engine. A pixel word (cmd = pixel) places the point
// c = center + pixel_step*(x, y) - floor(pixel_step*(size-1)/2) on each axis,
// then iterates z = z^2 + c in signed Q4.59 fixed point (exact 128-bit
// squares, products rounded toward minus infinity, results saturated) until
// |z|^2 >= 4 or max_iterations is reached, and returns one result word with
// the count and, for an escaped pixel, the color palette[count mod 255].
// A load word (cmd = load) writes one palette entry and returns nothing;
// indexes past the last entry are dropped. All arithmetic runs through one
// 32x32 multiplier that builds each 64x64 product from 32x32 partial products;
// one iteration runs two squares, the escape test, the cross product,
// rescale and update. The input is ready only while the engine is idle; a
// finished result sits in an output register, so the next word is taken
// while it waits. Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must write it only while idle, which the block does not enforce.
module mandelbrot_escape_pixel import mep_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mep_in_if.sink                i_item,
    mep_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL    = 9'b000000010,
        S_DIFF   = 9'b000000100,
        S_SAT    = 9'b000001000,
        S_TEST   = 9'b000010000,
        S_SCALE  = 9'b000100000,
        S_UPDATE = 9'b001000000,
        S_READ   = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

    // which product the multiplier is working on
    typedef enum logic [2:0] {
        OP_HALF   = 3'd0,
        OP_OFF    = 3'd1,
        OP_SQR_RE = 3'd2,
        OP_SQR_IM = 3'd3,
        OP_CROSS  = 3'd4
    } t_op;

    // Configuration registers
    t_val               r_center_re;
    t_val               r_center_im;
    logic [STEP_W-1:0]  r_step;
    logic [COUNT_W-1:0] r_max;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;

    // Sequencer
    t_state             r_state;
    t_state             n_state;
    t_op                r_op;
    t_op                n_op;
    logic               r_mul_start;
    logic               n_mul_start;
    logic               r_ov;

    // Pixel datapath
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic               r_axis;      // 0 while placing the real part
    t_val               r_cr;
    t_val               r_ci;
    t_val               r_zr;
    t_val               r_zi;
    t_wide              r_sr;
    t_wide              r_si;
    t_wide              r_pr;
    t_wide              r_mag;
    logic               r_neg;
    t_wide              r_sre;
    t_wide              r_sim;
    logic               r_nim;
    logic [COUNT_W-1:0] r_n;
    logic [PAL_AW-1:0]  r_pidx;      // r_n mod PALETTE_SIZE
    logic               r_esc;
    t_out_word          r_out;

    logic               accept;
    logic               out_load;
    logic               pal_rd;
    t_pal_wr            pal_wr;
    logic [RGB_W-1:0]   pal_rgb;
    t_val               mul_a;
    t_val               mul_b;
    logic               mul_done;
    t_wide              mul_prod;
    t_val               mag_re;
    t_val               mag_im;
    logic [WIDE_W:0]    sum_sq;
    logic               escape;
    logic [COUNT_W-1:0] n_inc;
    logic [PAL_AW-1:0]  pidx_inc;
    logic               sign_im;

    assign accept = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    assign o_result.valid   = r_ov;
    assign o_result.payload = r_out;

    assign mag_re   = magnitude(r_zr);
    assign mag_im   = magnitude(r_zi);
    assign sum_sq   = {1'b0, r_sr} + {1'b0, r_si};
    assign escape   = |sum_sq[WIDE_W:FOUR_BIT];
    assign n_inc    = r_n + COUNT_W'(1);
    assign pidx_inc = (r_pidx == PAL_AW'(PALETTE_SIZE - 1)) ? '0 : (r_pidx + PAL_AW'(1));
    assign sign_im  = r_zr[VAL_W-1] ^ r_zi[VAL_W-1];

    // Palette write straight from a load word
    always_comb begin
        pal_wr.en   = accept && (i_item.payload.cmd == CMD_LOAD)
                      && (32'(i_item.payload.palette_index) < PALETTE_SIZE);
        pal_wr.addr = PAL_AW'(i_item.payload.palette_index);
        pal_wr.rgb  = {i_item.payload.load_red, i_item.payload.load_green,
                       i_item.payload.load_blue};
    end

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_op)
            OP_HALF: begin
                mul_a = VAL_W'(r_step);
                mul_b = r_axis ? VAL_W'(span_of(r_height)) : VAL_W'(span_of(r_width));
            end
            OP_OFF: begin
                mul_a = VAL_W'(r_step);
                mul_b = r_axis ? VAL_W'(r_y) : VAL_W'(r_x);
            end
            OP_SQR_RE: begin
                mul_a = mag_re;
                mul_b = mag_re;
            end
            OP_SQR_IM: begin
                mul_a = mag_im;
                mul_b = mag_im;
            end
            OP_CROSS: begin
                mul_a = mag_re;
                mul_b = mag_im;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mep_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    mep_palette u_palette (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (pal_wr),
        .i_rd_en   (pal_rd),
        .i_rd_addr (r_pidx),
        .o_rd_rgb  (pal_rgb)
    );

    // Sequencer: placement (two products per axis), then per iteration
    // two squares, escape test, cross product, rescale, update.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_mul_start = 1'b0;
        out_load    = 1'b0;
        pal_rd      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_item.payload.cmd == CMD_PIXEL)) begin
                    n_state     = S_MUL;
                    n_op        = OP_HALF;
                    n_mul_start = 1'b1;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    unique case (r_op)
                        OP_HALF: begin
                            n_op        = OP_OFF;
                            n_mul_start = 1'b1;
                        end
                        OP_OFF:    n_state = S_DIFF;
                        OP_SQR_RE: begin
                            n_op        = OP_SQR_IM;
                            n_mul_start = 1'b1;
                        end
                        OP_SQR_IM: n_state = S_TEST;
                        OP_CROSS:  n_state = S_SCALE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_DIFF: n_state = S_SAT;
            S_SAT: begin
                if (!r_axis) begin
                    n_state     = S_MUL;
                    n_op        = OP_HALF;
                    n_mul_start = 1'b1;
                end else if (r_max == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_state     = S_MUL;
                    n_op        = OP_SQR_RE;
                    n_mul_start = 1'b1;
                end
            end
            S_TEST: begin
                if (escape) begin
                    n_state = S_READ;
                end else begin
                    n_state     = S_MUL;
                    n_op        = OP_CROSS;
                    n_mul_start = 1'b1;
                end
            end
            S_SCALE: n_state = S_UPDATE;
            S_UPDATE: begin
                if (n_inc == r_max) begin
                    n_state = S_FIN;
                end else begin
                    n_state     = S_MUL;
                    n_op        = OP_SQR_RE;
                    n_mul_start = 1'b1;
                end
            end
            S_READ: begin
                pal_rd  = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_ov || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_HALF;
            r_mul_start <= 1'b0;
            r_ov        <= 1'b0;
            r_center_re <= '0;
            r_center_im <= '0;
            r_step      <= STEP_W'(63'd2135039823345994);
            r_max       <= COUNT_W'(500);
            r_width     <= DIM_W'(1920);
            r_height    <= DIM_W'(1080);
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_mul_start <= n_mul_start;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CENTER_RE:    r_center_re <= i_cfg_data;
                    CFG_CENTER_IM:    r_center_im <= i_cfg_data;
                    CFG_PIXEL_STEP:   r_step      <= i_cfg_data[STEP_W-1:0];
                    CFG_MAX_ITER:     r_max       <= i_cfg_data[COUNT_W-1:0];
                    CFG_IMAGE_WIDTH:  r_width     <= i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: r_height    <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_x    <= i_item.payload.pixel_x;
                    r_y    <= i_item.payload.pixel_y;
                    r_axis <= 1'b0;
                    r_n    <= '0;
                    r_pidx <= '0;
                    r_esc  <= 1'b0;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    unique case (r_op)
                        OP_HALF:   r_sr <= mul_prod >> 1;
                        OP_OFF:    r_si <= mul_prod;
                        OP_SQR_RE: r_sr <= mul_prod;
                        OP_SQR_IM: r_si <= mul_prod;
                        OP_CROSS:  r_pr <= mul_prod << 1;
                        default: ;
                    endcase
                end
            end
            S_DIFF: begin
                // offset minus half span, as sign and magnitude
                if (r_si >= r_sr) begin
                    r_mag <= r_si - r_sr;
                    r_neg <= 1'b0;
                end else begin
                    r_mag <= r_sr - r_si;
                    r_neg <= 1'b1;
                end
            end
            S_SAT: begin
                if (!r_axis) begin
                    r_cr   <= sat_add(r_center_re, r_mag, r_neg);
                    r_zr   <= sat_add(r_center_re, r_mag, r_neg);
                    r_axis <= 1'b1;
                end else begin
                    r_ci <= sat_add(r_center_im, r_mag, r_neg);
                    r_zi <= sat_add(r_center_im, r_mag, r_neg);
                end
            end
            S_TEST: begin
                if (escape) begin
                    r_esc <= 1'b1;
                end
                // real part of z^2 as sign and magnitude
                if (r_sr < r_si) begin
                    r_mag <= r_si - r_sr;
                    r_neg <= 1'b1;
                end else begin
                    r_mag <= r_sr - r_si;
                    r_neg <= 1'b0;
                end
            end
            S_SCALE: begin
                r_sre <= wscale(r_mag, r_neg);
                r_sim <= wscale(r_pr, sign_im);
                r_nim <= sign_im;
            end
            S_UPDATE: begin
                r_zr   <= sat_add(r_cr, r_sre, r_neg);
                r_zi   <= sat_add(r_ci, r_sim, r_nim);
                r_n    <= n_inc;
                r_pidx <= pidx_inc;
            end
            S_READ: ;
            S_FIN: begin
                if (out_load) begin
                    r_out.out_x           <= r_x;
                    r_out.out_y           <= r_y;
                    r_out.escaped         <= r_esc;
                    r_out.iteration_count <= r_n;
                    r_out.red   <= r_esc ? pal_rgb[RGB_W-1:2*COLOR_W] : '0;
                    r_out.green <= r_esc ? pal_rgb[2*COLOR_W-1:COLOR_W] : '0;
                    r_out.blue  <= r_esc ? pal_rgb[COLOR_W-1:0] : '0;
                end
            end
            default: ;
        endcase
    end

    a_bounded_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.escaped) |->
            (r_out.red == '0 && r_out.green == '0 && r_out.blue == '0))
        else $error("bounded pixel carries a color");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_n <= r_max))
        else $error("iteration count past the limit");

    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL))
        else $error("product finished outside the multiply state");

    a_pidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (32'(r_pidx) < PALETTE_SIZE))
        else $error("palette index out of range");

endmodule

// ----- sv/mep_mul.sv -----
// 64x64 unsigned multiply over four 32x32 partial products.
module mep_mul import mep_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_val  i_a,
    input  t_val  i_b,
    output logic  o_done,
    output t_wide o_prod
);

    localparam int HALF_W = VAL_W / 2;

    t_val              r_a;
    t_val              r_b;
    logic [1:0]        r_step;
    logic              r_busy;
    logic [VAL_W-1:0]  r_pp;
    logic [1:0]        r_pp_sh;
    logic              r_pp_v;
    logic              r_pp_last;
    t_wide             r_acc;
    logic              r_done;

    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] b_half;
    t_wide             pp_shifted;

    assign a_half = r_step[1] ? r_a[VAL_W-1:HALF_W] : r_a[HALF_W-1:0];
    assign b_half = r_step[0] ? r_b[VAL_W-1:HALF_W] : r_b[HALF_W-1:0];
    assign pp_shifted = {{VAL_W{1'b0}}, r_pp} << {r_pp_sh, 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pp_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_pp_v <= r_busy && !i_start;
            r_done <= r_pp_v && r_pp_last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == 2'd3)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_step <= 2'd0;
            r_acc  <= '0;
        end else begin
            if (r_busy) begin
                r_pp      <= a_half * b_half;
                r_pp_sh   <= 2'(r_step[1]) + 2'(r_step[0]);
                r_pp_last <= (r_step == 2'd3);
                r_step    <= r_step + 2'd1;
            end
            if (r_pp_v) begin
                r_acc <= r_acc + pp_shifted;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!r_busy && !r_pp_v))
        else $error("multiplier started while busy");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##6 r_done)
        else $error("multiplier result not ready six cycles after start");

    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_pp_v && !r_busy))
        else $error("product still accumulating at done");

endmodule

// ----- sv/mep_palette.sv -----
// Color table with per-entry valid bits; an unwritten entry reads as zero.
module mep_palette import mep_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pal_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [PAL_AW-1:0] i_rd_addr,
    output logic [RGB_W-1:0]  o_rd_rgb
);

    logic [RGB_W-1:0]        r_mem [PALETTE_SIZE];
    logic [PALETTE_SIZE-1:0] r_valid;
    logic [RGB_W-1:0]        r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.rgb;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_rgb = r_rd_valid ? r_rd_data : '0;

endmodule
